@@ sv/blz_pkg.sv @@
// ============================================================================
// blz_pkg
// Shared types and constants for the backward LZ stream decoder.
// ============================================================================
`default_nettype none

package blz_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int HIST_DEPTH  = 8192;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int DISP_W      = 13;   // 12-bit field + 3
    localparam int MLEN_W      = 5;    // 4-bit field + 3
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    localparam logic [MLEN_W-1:0] MLEN_BIAS = MLEN_W'(3);
    localparam logic [DISP_W-1:0] DISP_BIAS = DISP_W'(3);
    localparam logic [3:0]        FLAG_BITS = 4'd8;

    typedef enum logic [1:0] {
        CMD_LIT  = 2'd0,
        CMD_COPY = 2'd1,
        CMD_END  = 2'd2
    } t_cmd_kind;

    typedef enum logic [1:0] {
        ST_COMPLETE  = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_DISP_FAR  = 2'd2,
        ST_LEN_OVER  = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [7:0]        lit;
        logic [MLEN_W-1:0] mlen;
        logic [DISP_W-1:0] disp;
        logic              last;
        t_status           status;
    } t_cmd;

endpackage

`default_nettype wire

@@ sv/blz_front.sv @@
// ============================================================================
// blz_front
// Parses compressed beats into literal, copy and end commands.
// ============================================================================
`default_nettype none

module blz_front (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [7:0]                      i_comp_byte,
    input  wire                             i_in_last,
    input  wire  [blz_pkg::LENGTH_BITS-1:0] i_out_length,
    input  wire                             i_q_full,
    output logic                            o_push,
    output blz_pkg::t_cmd                   o_cmd
);
    import blz_pkg::*;

    logic [7:0]             r_flags,     n_flags;
    logic [3:0]             r_bits_left, n_bits_left;
    logic [7:0]             r_first,     n_first;
    logic                   r_await,     n_await;
    logic [LENGTH_BITS-1:0] r_produced,  n_produced;
    logic                   r_done,      n_done;

    logic                   accept;
    logic [2:0]             bit_idx;
    logic [MLEN_W-1:0]      mlen;
    logic [DISP_W-1:0]      disp;
    logic [LENGTH_BITS-1:0] remaining;
    logic [LENGTH_BITS-1:0] prod_inc;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign bit_idx    = 3'(r_bits_left - 4'd1);
    assign mlen       = MLEN_W'(r_first[7:4]) + MLEN_BIAS;
    assign disp       = DISP_W'({r_first[3:0], i_comp_byte}) + DISP_BIAS;
    assign remaining  = i_out_length - r_produced;
    assign prod_inc   = r_produced + LENGTH_BITS'(1);

    always_comb begin
        n_flags     = r_flags;
        n_bits_left = r_bits_left;
        n_first     = r_first;
        n_await     = r_await;
        n_produced  = r_produced;
        n_done      = r_done;
        o_push      = 1'b0;
        o_cmd       = '0;
        o_cmd.kind  = CMD_END;
        o_cmd.status = ST_COMPLETE;
        if (accept) begin
            if (!r_done && r_produced >= i_out_length) begin
                o_push      = 1'b1;
                o_cmd.last  = 1'b1;
                n_done      = 1'b1;
            end else if (!r_done) begin
                if (r_bits_left == 4'd0) begin
                    n_flags     = i_comp_byte;
                    n_bits_left = FLAG_BITS;
                end else if (!r_flags[bit_idx]) begin
                    n_bits_left = r_bits_left - 4'd1;
                    o_push      = 1'b1;
                    o_cmd.kind  = CMD_LIT;
                    o_cmd.lit   = i_comp_byte;
                    n_produced  = prod_inc;
                    if (prod_inc == i_out_length) begin
                        o_cmd.last = 1'b1;
                        n_done     = 1'b1;
                    end
                end else if (!r_await) begin
                    n_first = i_comp_byte;
                    n_await = 1'b1;
                end else begin
                    n_await     = 1'b0;
                    n_bits_left = r_bits_left - 4'd1;
                    o_push      = 1'b1;
                    if (LENGTH_BITS'(disp) > r_produced) begin
                        o_cmd.last   = 1'b1;
                        o_cmd.status = ST_DISP_FAR;
                        n_done       = 1'b1;
                    end else if (LENGTH_BITS'(mlen) > remaining) begin
                        o_cmd.last   = 1'b1;
                        o_cmd.status = ST_LEN_OVER;
                        n_done       = 1'b1;
                    end else begin
                        o_cmd.kind = CMD_COPY;
                        o_cmd.mlen = mlen;
                        o_cmd.disp = disp;
                        n_produced = r_produced + LENGTH_BITS'(mlen);
                        if (remaining == LENGTH_BITS'(mlen)) begin
                            o_cmd.last = 1'b1;
                            n_done     = 1'b1;
                        end
                    end
                end
            end
            if (i_in_last) begin
                // final beat closes the frame; flag it unless already ended
                if (!n_done) begin
                    o_push       = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.status = ST_EXHAUSTED;
                end
                n_flags     = '0;
                n_bits_left = '0;
                n_first     = '0;
                n_await     = 1'b0;
                n_produced  = '0;
                n_done      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags     <= '0;
            r_bits_left <= '0;
            r_first     <= '0;
            r_await     <= 1'b0;
            r_produced  <= '0;
            r_done      <= 1'b0;
        end else begin
            r_flags     <= n_flags;
            r_bits_left <= n_bits_left;
            r_first     <= n_first;
            r_await     <= n_await;
            r_produced  <= n_produced;
            r_done      <= n_done;
        end
    end

endmodule

`default_nettype wire

@@ sv/blz_queue.sv @@
// ============================================================================
// blz_queue
// Small command FIFO between the parser and the copy engine.
// ============================================================================
`default_nettype none

module blz_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  blz_pkg::t_cmd       i_push_data,
    output logic                o_full,
    input  wire                 i_pop,
    output blz_pkg::t_cmd       o_pop_data,
    output logic                o_empty
);
    import blz_pkg::*;

    t_cmd             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]    r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full     = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty    = (r_count == '0);
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + Q_AW'(1) : r_wr_ptr;
        n_rd_ptr = do_pop  ? r_rd_ptr + Q_AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + (Q_AW+1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ sv/blz_back.sv @@
// ============================================================================
// blz_back
// Copy engine: history ring, staging register and output register.
// ============================================================================
`default_nettype none

module blz_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_q_empty,
    input  blz_pkg::t_cmd       i_q_data,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_byte_valid,
    output logic                o_out_last,
    output logic [1:0]          o_end_status
);
    import blz_pkg::*;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_COPY = 2'b10
    } t_back_state;

    t_back_state        r_state, n_state;
    logic [MLEN_W-1:0]  r_cnt;
    logic [HIST_AW-1:0] r_raddr;
    logic               r_cmd_last;
    t_status            r_cmd_status;
    logic [HIST_AW-1:0] r_ipos;
    logic [HIST_AW-1:0] r_wptr;

    logic [7:0]         r_mem [HIST_DEPTH];
    logic [7:0]         r_rd_data;

    // staging beat
    logic               r_s_vld;
    logic               r_s_ram;
    logic [7:0]         r_s_byte;
    logic               r_s_bv;
    logic               r_s_last;
    t_status            r_s_status;

    logic               r_o_valid;
    logic [7:0]         r_o_byte;
    logic               r_o_bv;
    logic               r_o_last;
    t_status            r_o_status;

    logic               out_free;
    logic               adv;
    logic               load_ok;
    logic               issue;
    logic               pop_lit_end;
    logic [7:0]         s_byte;
    logic [HIST_AW:0]   ipos_x;
    logic [HIST_AW:0]   disp_x;
    logic [HIST_AW-1:0] src_addr;

    assign out_free = !r_o_valid || i_out_ready;
    assign adv      = r_s_vld && out_free;
    assign load_ok  = !r_s_vld || adv;
    assign issue    = (r_state == BK_COPY) && load_ok;
    assign o_q_pop  = (r_state == BK_IDLE) && load_ok && !i_q_empty;
    assign pop_lit_end = o_q_pop && (i_q_data.kind != CMD_COPY);
    assign s_byte   = r_s_ram ? r_rd_data : r_s_byte;

    // source of a copy, modulo ring depth
    assign ipos_x   = (HIST_AW+1)'(r_ipos);
    assign disp_x   = (HIST_AW+1)'(i_q_data.disp);
    always_comb begin
        if (ipos_x >= disp_x) begin
            src_addr = HIST_AW'(ipos_x - disp_x);
        end else begin
            src_addr = HIST_AW'(ipos_x + (HIST_AW+1)'(HIST_DEPTH) - disp_x);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (o_q_pop && i_q_data.kind == CMD_COPY) begin
                    n_state = BK_COPY;
                end
            end
            BK_COPY: begin
                if (issue && r_cnt == MLEN_W'(1)) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // history ring
    always_ff @(posedge i_clk) begin
        if (adv && r_s_bv) begin
            r_mem[r_wptr] <= s_byte;
        end
        if (issue) begin
            r_rd_data <= r_mem[r_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_data.kind == CMD_COPY) begin
            r_cnt        <= i_q_data.mlen;
            r_raddr      <= src_addr;
            r_cmd_last   <= i_q_data.last;
            r_cmd_status <= i_q_data.status;
        end else if (issue) begin
            r_cnt   <= r_cnt - MLEN_W'(1);
            r_raddr <= (r_raddr == HIST_AW'(HIST_DEPTH - 1)) ? '0 : r_raddr + HIST_AW'(1);
        end
        if (issue) begin
            r_s_ram    <= 1'b1;
            r_s_byte   <= '0;
            r_s_bv     <= 1'b1;
            r_s_last   <= (r_cnt == MLEN_W'(1)) && r_cmd_last;
            r_s_status <= (r_cnt == MLEN_W'(1)) ? r_cmd_status : ST_COMPLETE;
        end else if (pop_lit_end) begin
            r_s_ram    <= 1'b0;
            r_s_byte   <= (i_q_data.kind == CMD_LIT) ? i_q_data.lit : 8'd0;
            r_s_bv     <= (i_q_data.kind == CMD_LIT);
            r_s_last   <= i_q_data.last;
            r_s_status <= i_q_data.status;
        end
        if (adv) begin
            r_o_byte   <= s_byte;
            r_o_bv     <= r_s_bv;
            r_o_last   <= r_s_last;
            r_o_status <= r_s_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_s_vld   <= 1'b0;
            r_o_valid <= 1'b0;
            r_ipos    <= '0;
            r_wptr    <= '0;
        end else begin
            r_state <= n_state;
            if (issue || pop_lit_end) begin
                r_s_vld <= 1'b1;
            end else if (adv) begin
                r_s_vld <= 1'b0;
            end
            if (adv) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (issue || (pop_lit_end && i_q_data.kind == CMD_LIT)) begin
                r_ipos <= (r_ipos == HIST_AW'(HIST_DEPTH - 1)) ? '0 : r_ipos + HIST_AW'(1);
            end
            if (adv && r_s_bv) begin
                r_wptr <= (r_wptr == HIST_AW'(HIST_DEPTH - 1)) ? '0 : r_wptr + HIST_AW'(1);
            end
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_byte   = r_o_byte;
    assign o_byte_valid = r_o_bv;
    assign o_out_last   = r_o_last;
    assign o_end_status = r_o_status;

endmodule

`default_nettype wire

@@ sv/backward_lz_stream_decoder.sv @@
// Path: a literal or end beat passes the command queue, the staging register and
// the output register; a copy's first byte also waits for the engine's setup.
// Throughput: one input beat per cycle into the parser while the queue has room; results
// leave at one beat per cycle with the output ready, each copy costing an engine setup step.
// The engine's single read port on the history ring sets the copy rate.
// Reset (i_rst_n low, synchronous) clears parser state, the queue and the
// output register; the history ring is not cleared.
// ============================================================================
// backward_lz_stream_decoder
// Backward LZ77 decoder: parser front end, command queue, copy engine.
// ============================================================================
`default_nettype none

module backward_lz_stream_decoder (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration: output_length
    input  wire                             i_cfg_we,
    input  wire  [blz_pkg::LENGTH_BITS-1:0] i_cfg_wdata,
    // compressed input beats, last byte of the region first
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [7:0]                      i_comp_byte,
    input  wire                             i_in_last,
    // decoded result beats
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [7:0]                      o_out_byte,
    output logic                            o_byte_valid,
    output logic                            o_out_last,
    output logic [1:0]                      o_end_status
);
    import blz_pkg::*;

    logic [LENGTH_BITS-1:0] r_out_length;

    logic   push;
    t_cmd   push_cmd;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    t_cmd   q_cmd;

    // output_length register; the user must write it only while the decoder is idle, the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_length <= '0;
        end else if (i_cfg_we) begin
            r_out_length <= i_cfg_wdata;
        end
    end

    // Front end: flag-bit walk, match header decode, bounds checks and
    // frame bookkeeping. It knows the produced count exactly, so every
    // error and end-of-frame decision is made here.
    blz_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_comp_byte  (i_comp_byte),
        .i_in_last    (i_in_last),
        .i_out_length (r_out_length),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // Decouples the parser from copy bursts of up to 18 bytes.
    blz_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_cmd),
        .o_empty     (q_empty)
    );

    // Back end: writes every produced byte to the history ring and replays
    // copies from it, one byte per cycle while the output is not stalled,
    // through a staging register and the output register.
    blz_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_data     (q_cmd),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_out_last   (o_out_last),
        .o_end_status (o_end_status)
    );

endmodule

`default_nettype wire
